FILE: rtl/ecb_pkg.sv
// shared types, constants and tables for the camera basis pipeline
package ecb_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int ATAN_LEN = 24;
	localparam int STEP_W = $clog2(ATAN_LEN);

	localparam int ANG_W = 17;
	localparam int ZW = 25;
	localparam int CW = 32;
	localparam int VW = 16;
	localparam int SQ_W = 63;
	localparam int ROOT_W = 31;
	localparam int BITPOS_W = 6;
	localparam int NUM_W = 47;
	localparam int DEN_W = 33;
	localparam int QW = 15;
	localparam int QSH_W = $clog2(QW);
	localparam int ANG_SHIFT = 10;
	localparam int NUM_SHIFT = 15;
	localparam int PROD_SHIFT = 30;

	localparam int NORM_LAT = ROOT_W + QW + 4;
	localparam int CORE_LAT = 3 * NORM_LAT + CORDIC_STEPS + 4;

	localparam logic signed [ANG_W-1:0] FULL_TURN = 17'sd23040;
	localparam logic signed [ANG_W-1:0] HALF_TURN = 17'sd11520;
	localparam logic signed [ANG_W-1:0] QUARTER_TURN = 17'sd5760;
	localparam logic signed [ANG_W-1:0] PITCH_LIMIT = 17'sd5696;
	localparam logic signed [CW-1:0] CORDIC_K = 32'sd652032875;
	localparam logic [QW-1:0] ONE_Q14 = 15'd16384;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_WORLD_UP_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WORLD_UP_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WORLD_UP_Z = 2'd2;
	localparam logic signed [VW-1:0] WORLD_UP_X_RST = 16'sd0;
	localparam logic signed [VW-1:0] WORLD_UP_Y_RST = 16'sd16384;
	localparam logic signed [VW-1:0] WORLD_UP_Z_RST = 16'sd0;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [ZW-1:0] z;
		logic                 neg;
	} cordic_word_t;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
	} wide_vec_t;

	typedef struct packed {
		logic signed [VW-1:0] x;
		logic signed [VW-1:0] y;
		logic signed [VW-1:0] z;
	} vec_t;

	typedef struct packed {
		vec_t v;
		logic ok;
	} vec_ok_t;

	typedef struct packed {
		logic [2:0][CW-1:0] mag;
		logic [2:0]         neg;
	} norm_pay_t;

	typedef struct packed {
		logic [SQ_W-1:0] n;
		logic [SQ_W-1:0] res;
		norm_pay_t       pay;
	} sqrt_word_t;

	typedef struct packed {
		logic [NUM_W-1:0] rem;
		logic [DEN_W-1:0] den;
		logic [QW-1:0]    quo;
		logic             neg;
		logic             zero;
	} div_lane_t;

	function automatic logic signed [ZW-1:0] atan_deg16(input logic [STEP_W-1:0] i);
		logic signed [ZW-1:0] a;
		case (i)
			5'd0: a = 25'sd2949120;
			5'd1: a = 25'sd1740967;
			5'd2: a = 25'sd919879;
			5'd3: a = 25'sd466945;
			5'd4: a = 25'sd234379;
			5'd5: a = 25'sd117304;
			5'd6: a = 25'sd58666;
			5'd7: a = 25'sd29335;
			5'd8: a = 25'sd14668;
			5'd9: a = 25'sd7334;
			5'd10: a = 25'sd3667;
			5'd11: a = 25'sd1833;
			5'd12: a = 25'sd917;
			5'd13: a = 25'sd458;
			5'd14: a = 25'sd229;
			5'd15: a = 25'sd115;
			5'd16: a = 25'sd57;
			5'd17: a = 25'sd29;
			5'd18: a = 25'sd14;
			5'd19: a = 25'sd7;
			5'd20: a = 25'sd4;
			5'd21: a = 25'sd2;
			5'd22: a = 25'sd1;
			default: a = 25'sd0;
		endcase
		return a;
	endfunction

endpackage

FILE: rtl/ecb_cordic_cell.sv
// one rotation step of the sine/cosine chain
module ecb_cordic_cell (
	input  logic                        clk,
	input  logic [ecb_pkg::STEP_W-1:0]  step,
	input  ecb_pkg::cordic_word_t       din,
	output ecb_pkg::cordic_word_t       dout
);
	logic signed [ecb_pkg::CW-1:0] dx;
	logic signed [ecb_pkg::CW-1:0] dy;
	logic signed [ecb_pkg::ZW-1:0] ang;
	ecb_pkg::cordic_word_t nxt;

	always_comb begin
		dx = $signed(din.y) >>> step;
		dy = $signed(din.x) >>> step;
		ang = ecb_pkg::atan_deg16(step);
		nxt = din;
		if (!din.z[ecb_pkg::ZW-1]) begin
			nxt.x = din.x - dx;
			nxt.y = din.y + dy;
			nxt.z = din.z - ang;
		end else begin
			nxt.x = din.x + dx;
			nxt.y = din.y - dy;
			nxt.z = din.z + ang;
		end
	end

	always_ff @(posedge clk) begin
		dout <= nxt;
	end
endmodule

FILE: rtl/ecb_sqrt_cell.sv
// one root bit of the integer square root chain
module ecb_sqrt_cell (
	input  logic                          clk,
	input  logic [ecb_pkg::BITPOS_W-1:0]  bitpos,
	input  ecb_pkg::sqrt_word_t           din,
	output ecb_pkg::sqrt_word_t           dout
);
	logic [ecb_pkg::SQ_W-1:0] bitv;
	logic [ecb_pkg::SQ_W-1:0] trial;
	ecb_pkg::sqrt_word_t nxt;

	always_comb begin
		bitv = {{(ecb_pkg::SQ_W-1){1'b0}}, 1'b1} << bitpos;
		trial = din.res + bitv;
		nxt = din;
		if (din.n >= trial) begin
			nxt.n = din.n - trial;
			nxt.res = (din.res >> 1) + bitv;
		end else begin
			nxt.res = din.res >> 1;
		end
	end

	always_ff @(posedge clk) begin
		dout <= nxt;
	end
endmodule

FILE: rtl/ecb_div_cell.sv
// one quotient bit of the restoring divider chain
module ecb_div_cell (
	input  logic                        clk,
	input  logic [ecb_pkg::QSH_W-1:0]   sh,
	input  ecb_pkg::div_lane_t          din,
	output ecb_pkg::div_lane_t          dout
);
	logic [ecb_pkg::NUM_W-1:0] dsh;
	logic ge;
	ecb_pkg::div_lane_t nxt;

	always_comb begin
		dsh = ecb_pkg::NUM_W'(din.den) << sh;
		ge = din.rem >= dsh;
		nxt = din;
		nxt.rem = ge ? din.rem - dsh : din.rem;
		nxt.quo = {din.quo[ecb_pkg::QW-2:0], ge};
	end

	always_ff @(posedge clk) begin
		dout <= nxt;
	end
endmodule

FILE: rtl/ecb_norm.sv
// vector normalizer: squares, root chain, divider chains, rounding to q1.14
module ecb_norm (
	input  logic                clk,
	input  ecb_pkg::wide_vec_t  vin,
	output ecb_pkg::vec_t       vout,
	output logic                ok
);
	logic signed [ecb_pkg::CW-1:0] comp [3];
	logic [ecb_pkg::CW-1:0] mag [3];
	logic [2*ecb_pkg::CW-1:0] sq_s1 [3];
	ecb_pkg::norm_pay_t pay_s1;
	logic [ecb_pkg::SQ_W-1:0] sum_s2;
	ecb_pkg::norm_pay_t pay_s2;
	ecb_pkg::sqrt_word_t sw [ecb_pkg::ROOT_W+1];
	logic [ecb_pkg::ROOT_W-1:0] len;
	ecb_pkg::div_lane_t ln [3][ecb_pkg::QW+1];
	logic [ecb_pkg::QW-1:0] qc [3];
	logic signed [ecb_pkg::VW-1:0] res [3];
	logic ok_q;

	assign comp[0] = vin.x;
	assign comp[1] = vin.y;
	assign comp[2] = vin.z;
	assign len = sw[ecb_pkg::ROOT_W].res[ecb_pkg::ROOT_W-1:0];

	for (genvar k = 0; k < 3; k++) begin : g_lane
		assign mag[k] = comp[k][ecb_pkg::CW-1] ? ecb_pkg::CW'(-comp[k]) : comp[k];

		always_ff @(posedge clk) begin
			sq_s1[k] <= mag[k] * mag[k];
			pay_s1.mag[k] <= mag[k];
			pay_s1.neg[k] <= comp[k][ecb_pkg::CW-1];
		end

		always_ff @(posedge clk) begin
			ln[k][0].rem <= (ecb_pkg::NUM_W'(sw[ecb_pkg::ROOT_W].pay.mag[k]) << ecb_pkg::NUM_SHIFT)
				+ ecb_pkg::NUM_W'(len);
			ln[k][0].den <= ecb_pkg::DEN_W'({len, 1'b0});
			ln[k][0].quo <= '0;
			ln[k][0].neg <= sw[ecb_pkg::ROOT_W].pay.neg[k];
			ln[k][0].zero <= (len == '0);
		end

		for (genvar j = 0; j < ecb_pkg::QW; j++) begin : g_div
			ecb_div_cell u_div (
				.clk  (clk),
				.sh   (ecb_pkg::QSH_W'(ecb_pkg::QW - 1 - j)),
				.din  (ln[k][j]),
				.dout (ln[k][j+1])
			);
		end

		assign qc[k] = (ln[k][ecb_pkg::QW].quo > ecb_pkg::ONE_Q14) ? ecb_pkg::ONE_Q14
			: ln[k][ecb_pkg::QW].quo;

		always_ff @(posedge clk) begin
			if (ln[k][ecb_pkg::QW].zero) begin
				res[k] <= '0;
			end else if (ln[k][ecb_pkg::QW].neg) begin
				res[k] <= -$signed(ecb_pkg::VW'(qc[k]));
			end else begin
				res[k] <= $signed(ecb_pkg::VW'(qc[k]));
			end
		end
	end

	always_ff @(posedge clk) begin
		sum_s2 <= ecb_pkg::SQ_W'(sq_s1[0]) + ecb_pkg::SQ_W'(sq_s1[1])
			+ ecb_pkg::SQ_W'(sq_s1[2]);
		pay_s2 <= pay_s1;
		ok_q <= !ln[0][ecb_pkg::QW].zero;
	end

	assign sw[0].n = sum_s2;
	assign sw[0].res = '0;
	assign sw[0].pay = pay_s2;

	for (genvar j = 0; j < ecb_pkg::ROOT_W; j++) begin : g_sqrt
		ecb_sqrt_cell u_sqrt (
			.clk    (clk),
			.bitpos (ecb_pkg::BITPOS_W'(2 * (ecb_pkg::ROOT_W - 1 - j))),
			.din    (sw[j]),
			.dout   (sw[j+1])
		);
	end

	assign vout.x = res[0];
	assign vout.y = res[1];
	assign vout.z = res[2];
	assign ok = ok_q;
endmodule

FILE: rtl/euler_camera_basis_core.sv
// camera basis top level: angle prep, cordic chains, three normalizers, delay lines
// Fully pipelined: one word may be started every clock cycle and busy never rises.
// Each result appears on the result ports for one cycle, marked by done, once its
// word has passed the 16-step cordic chain and the 31-cell square root and 15-cell
// divider chains of the three normalizers. The receiver cannot stall the block, so
// done must be taken when it is shown. World up registers are written through the
// cfg port, which is always ready; the user must write them only while no word is
// in flight, as the block itself does not enforce this.
module euler_camera_basis_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic signed [15:0]                  yaw_angle,
	input  logic signed [15:0]                  pitch_angle,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [ecb_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [15:0]                         cfg_data,
	output logic                                done,
	output logic signed [15:0]                  front_x,
	output logic signed [15:0]                  front_y,
	output logic signed [15:0]                  front_z,
	output logic signed [15:0]                  right_x,
	output logic signed [15:0]                  right_y,
	output logic signed [15:0]                  right_z,
	output logic signed [15:0]                  up_x,
	output logic signed [15:0]                  up_y,
	output logic signed [15:0]                  up_z,
	output logic                                degenerate
);
	localparam int NL = ecb_pkg::NORM_LAT;
	localparam int FD_N = 2 * NL + 2;
	localparam int RD_N = NL + 1;

	logic signed [ecb_pkg::VW-1:0] wu_x_q, wu_y_q, wu_z_q;
	logic [ecb_pkg::CORE_LAT-1:0] vld_q;

	logic signed [ecb_pkg::ANG_W-1:0] yaw_e, t1, t2, t3, pitch_e, pitch_c;
	logic yneg;
	ecb_pkg::cordic_word_t yw_s1, pw_s1;
	ecb_pkg::cordic_word_t yc [ecb_pkg::CORDIC_STEPS+1];
	ecb_pkg::cordic_word_t pc [ecb_pkg::CORDIC_STEPS+1];

	logic signed [ecb_pkg::CW-1:0] cy, sy;
	logic signed [2*ecb_pkg::CW-1:0] prod_x_s2, prod_z_s2;
	logic signed [ecb_pkg::CW-1:0] sp_s2;
	ecb_pkg::wide_vec_t raw;

	ecb_pkg::vec_t front, right, up;
	logic ok1, ok2, ok3;
	ecb_pkg::vec_ok_t fd_q [FD_N];
	ecb_pkg::vec_ok_t rd_q [RD_N];
	ecb_pkg::vec_t fmid;

	logic signed [2*ecb_pkg::VW:0] c1x, c1y, c1z, c2x, c2y, c2z;
	ecb_pkg::wide_vec_t cr1_s3, cr2_s4;

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wu_x_q <= ecb_pkg::WORLD_UP_X_RST;
			wu_y_q <= ecb_pkg::WORLD_UP_Y_RST;
			wu_z_q <= ecb_pkg::WORLD_UP_Z_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				ecb_pkg::REG_WORLD_UP_X: wu_x_q <= $signed(cfg_data);
				ecb_pkg::REG_WORLD_UP_Y: wu_y_q <= $signed(cfg_data);
				ecb_pkg::REG_WORLD_UP_Z: wu_z_q <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[ecb_pkg::CORE_LAT-2:0], start && !busy};
		end
	end

	// yaw reduction to one half turn, pitch clamp
	always_comb begin
		yaw_e = ecb_pkg::ANG_W'(yaw_angle);
		t1 = (yaw_e >= ecb_pkg::HALF_TURN) ? yaw_e - ecb_pkg::FULL_TURN : yaw_e;
		t2 = (t1 < -ecb_pkg::HALF_TURN) ? t1 + ecb_pkg::FULL_TURN : t1;
		yneg = 1'b0;
		t3 = t2;
		if (t2 > ecb_pkg::QUARTER_TURN) begin
			t3 = t2 - ecb_pkg::HALF_TURN;
			yneg = 1'b1;
		end else if (t2 < -ecb_pkg::QUARTER_TURN) begin
			t3 = t2 + ecb_pkg::HALF_TURN;
			yneg = 1'b1;
		end
		pitch_e = ecb_pkg::ANG_W'(pitch_angle);
		pitch_c = pitch_e;
		if (pitch_e > ecb_pkg::PITCH_LIMIT) begin
			pitch_c = ecb_pkg::PITCH_LIMIT;
		end else if (pitch_e < -ecb_pkg::PITCH_LIMIT) begin
			pitch_c = -ecb_pkg::PITCH_LIMIT;
		end
	end

	always_ff @(posedge clk) begin
		yw_s1.x <= ecb_pkg::CORDIC_K;
		yw_s1.y <= '0;
		yw_s1.z <= ecb_pkg::ZW'(t3) <<< ecb_pkg::ANG_SHIFT;
		yw_s1.neg <= yneg;
		pw_s1.x <= ecb_pkg::CORDIC_K;
		pw_s1.y <= '0;
		pw_s1.z <= ecb_pkg::ZW'(pitch_c) <<< ecb_pkg::ANG_SHIFT;
		pw_s1.neg <= 1'b0;
	end

	assign yc[0] = yw_s1;
	assign pc[0] = pw_s1;

	for (genvar i = 0; i < ecb_pkg::CORDIC_STEPS; i++) begin : g_cordic
		ecb_cordic_cell u_yaw (
			.clk  (clk),
			.step (ecb_pkg::STEP_W'(i)),
			.din  (yc[i]),
			.dout (yc[i+1])
		);
		ecb_cordic_cell u_pitch (
			.clk  (clk),
			.step (ecb_pkg::STEP_W'(i)),
			.din  (pc[i]),
			.dout (pc[i+1])
		);
	end

	assign cy = yc[ecb_pkg::CORDIC_STEPS].neg ? -yc[ecb_pkg::CORDIC_STEPS].x
		: yc[ecb_pkg::CORDIC_STEPS].x;
	assign sy = yc[ecb_pkg::CORDIC_STEPS].neg ? -yc[ecb_pkg::CORDIC_STEPS].y
		: yc[ecb_pkg::CORDIC_STEPS].y;

	always_ff @(posedge clk) begin
		prod_x_s2 <= cy * pc[ecb_pkg::CORDIC_STEPS].x;
		prod_z_s2 <= sy * pc[ecb_pkg::CORDIC_STEPS].x;
		sp_s2 <= pc[ecb_pkg::CORDIC_STEPS].y;
	end

	assign raw.x = prod_x_s2[ecb_pkg::PROD_SHIFT+ecb_pkg::CW-1:ecb_pkg::PROD_SHIFT];
	assign raw.y = sp_s2;
	assign raw.z = prod_z_s2[ecb_pkg::PROD_SHIFT+ecb_pkg::CW-1:ecb_pkg::PROD_SHIFT];

	ecb_norm u_norm_front (
		.clk  (clk),
		.vin  (raw),
		.vout (front),
		.ok   (ok1)
	);

	// front x world up
	always_comb begin
		c1x = front.y * wu_z_q - front.z * wu_y_q;
		c1y = front.z * wu_x_q - front.x * wu_z_q;
		c1z = front.x * wu_y_q - front.y * wu_x_q;
	end

	always_ff @(posedge clk) begin
		cr1_s3.x <= ecb_pkg::CW'(c1x);
		cr1_s3.y <= ecb_pkg::CW'(c1y);
		cr1_s3.z <= ecb_pkg::CW'(c1z);
	end

	ecb_norm u_norm_right (
		.clk  (clk),
		.vin  (cr1_s3),
		.vout (right),
		.ok   (ok2)
	);

	always_ff @(posedge clk) begin
		fd_q[0] <= '{v: front, ok: ok1};
		for (int k = 1; k < FD_N; k++) begin
			fd_q[k] <= fd_q[k-1];
		end
		rd_q[0] <= '{v: right, ok: ok2};
		for (int k = 1; k < RD_N; k++) begin
			rd_q[k] <= rd_q[k-1];
		end
	end

	assign fmid = fd_q[NL].v;

	// right x front
	always_comb begin
		c2x = right.y * fmid.z - right.z * fmid.y;
		c2y = right.z * fmid.x - right.x * fmid.z;
		c2z = right.x * fmid.y - right.y * fmid.x;
	end

	always_ff @(posedge clk) begin
		cr2_s4.x <= ecb_pkg::CW'(c2x);
		cr2_s4.y <= ecb_pkg::CW'(c2y);
		cr2_s4.z <= ecb_pkg::CW'(c2z);
	end

	ecb_norm u_norm_up (
		.clk  (clk),
		.vin  (cr2_s4),
		.vout (up),
		.ok   (ok3)
	);

	assign done = vld_q[ecb_pkg::CORE_LAT-1];
	assign front_x = fd_q[FD_N-1].v.x;
	assign front_y = fd_q[FD_N-1].v.y;
	assign front_z = fd_q[FD_N-1].v.z;
	assign right_x = rd_q[RD_N-1].v.x;
	assign right_y = rd_q[RD_N-1].v.y;
	assign right_z = rd_q[RD_N-1].v.z;
	assign up_x = up.x;
	assign up_y = up.y;
	assign up_z = up.z;
	assign degenerate = !(fd_q[FD_N-1].ok && rd_q[RD_N-1].ok && ok3);

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##(ecb_pkg::CORE_LAT) done)
		else $error("result word missing after pipeline latency");

	a_front_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (front_x <= 16'sd16384 && front_x >= -16'sd16384
			&& front_z <= 16'sd16384 && front_z >= -16'sd16384))
		else $error("front component out of unit range");

	a_front_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !degenerate |-> (front_x != 0 || front_y != 0 || front_z != 0))
		else $error("zero front on a good word");

	a_up_follows_right: assert property (@(posedge clk) disable iff (!arst_n)
		done && right_x == 0 && right_y == 0 && right_z == 0
			|-> (up_x == 0 && up_y == 0 && up_z == 0 && degenerate))
		else $error("up not cleared with zero right");
endmodule
